FILE: sv/mfau_pkg.sv
// ----------------------------------------------------------------------------
// mfau_pkg
// Shared types and constants of the motor feedback angle unwrap block.
// ----------------------------------------------------------------------------
package mfau_pkg;

  // default motor counts
  localparam int NUM_CHASSIS_DEFAULT = 4;
  localparam int NUM_AUX_DEFAULT     = 2;

  // number of zero-offset registers per group
  localparam int NUM_CHASSIS_OFFSETS = 4;
  localparam int NUM_AUX_OFFSETS     = 2;

  // field widths
  localparam int ID_W    = 11;
  localparam int RAW_W   = 16;
  localparam int WORD_W  = 16;
  localparam int TEMP_W  = 8;
  localparam int IDX_W   = 2;
  localparam int TC_W    = 24;
  localparam int ANG_W   = 22;
  localparam int TOTAL_W = 43;

  // fixed point scaling: one count is 45 q10 degrees, one turn 360 degrees
  localparam int FRAC_BITS        = 10;
  localparam int COUNT_DEG_Q10    = 45;
  localparam int TURN_DEG         = 360;
  localparam int HALF_TURN_COUNTS = 4096;

  localparam int DIFF_W   = RAW_W + 1;
  localparam int TC360_W  = TC_W + 9;
  localparam int REL45_W  = DIFF_W + 6;
  localparam int STATE_W  = RAW_W + TC_W;

  localparam logic signed [TC_W-1:0] TC_MAX = {1'b0, {(TC_W-1){1'b1}}};
  localparam logic signed [TC_W-1:0] TC_MIN = {1'b1, {(TC_W-1){1'b0}}};

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CHASSIS_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUX_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_CHASSIS0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_CHASSIS1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_CHASSIS2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_CHASSIS3 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_AUX0     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_AUX1     = 3'd7;

  localparam logic [ID_W-1:0] CHASSIS_BASE_RESET = 11'd513;
  localparam logic [ID_W-1:0] AUX_BASE_RESET     = 11'd517;

  typedef struct packed {
    logic [ID_W-1:0]                               chassis_base;
    logic [ID_W-1:0]                               aux_base;
    logic [NUM_CHASSIS_OFFSETS-1:0][RAW_W-1:0]     offset_chassis;
    logic [NUM_AUX_OFFSETS-1:0][RAW_W-1:0]         offset_aux;
  } cfg_t;

  typedef struct packed {
    logic             matched;
    logic             group;
    logic [IDX_W-1:0] motor_index;
    logic [RAW_W-1:0] offset;
  } dec_t;

endpackage

FILE: sv/mfau_ram.sv
// ----------------------------------------------------------------------------
// mfau_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mfau_decode.sv
// ----------------------------------------------------------------------------
// mfau_decode
// Maps a frame identifier onto a motor slot and selects its zero offset.
// ----------------------------------------------------------------------------
module mfau_decode #(
  parameter int NUM_CHASSIS_MOTORS = mfau_pkg::NUM_CHASSIS_DEFAULT,
  parameter int NUM_AUX_MOTORS     = mfau_pkg::NUM_AUX_DEFAULT,
  localparam int SLOTS  = NUM_CHASSIS_MOTORS + NUM_AUX_MOTORS,
  localparam int SLOT_W = $clog2(SLOTS)
) (
  input  logic [mfau_pkg::ID_W-1:0] frame_id_i,
  input  mfau_pkg::cfg_t            cfg_i,
  output mfau_pkg::dec_t            dec_o,
  output logic [SLOT_W-1:0]         slot_o
);

  localparam int ID_W = mfau_pkg::ID_W;

  logic [ID_W:0] ch_off;
  logic [ID_W:0] aux_off;
  logic          ch_hit;
  logic          aux_hit;

  // a borrow out of the subtraction means the identifier lies below the base
  assign ch_off  = {1'b0, frame_id_i} - {1'b0, cfg_i.chassis_base};
  assign aux_off = {1'b0, frame_id_i} - {1'b0, cfg_i.aux_base};
  assign ch_hit  = !ch_off[ID_W] && (ch_off[ID_W-1:0] < ID_W'(NUM_CHASSIS_MOTORS));
  assign aux_hit = !aux_off[ID_W] && (aux_off[ID_W-1:0] < ID_W'(NUM_AUX_MOTORS));

  always_comb begin
    dec_o  = '0;
    slot_o = '0;
    if (ch_hit) begin
      dec_o.matched     = 1'b1;
      dec_o.group       = 1'b0;
      dec_o.motor_index = ch_off[mfau_pkg::IDX_W-1:0];
      slot_o            = ch_off[SLOT_W-1:0];
      if (ch_off[ID_W-1:0] < ID_W'(mfau_pkg::NUM_CHASSIS_OFFSETS)) begin
        dec_o.offset = cfg_i.offset_chassis[ch_off[1:0]];
      end
    end else if (aux_hit) begin
      dec_o.matched     = 1'b1;
      dec_o.group       = 1'b1;
      dec_o.motor_index = aux_off[mfau_pkg::IDX_W-1:0];
      slot_o            = SLOT_W'(NUM_CHASSIS_MOTORS) + aux_off[SLOT_W-1:0];
      if (aux_off[ID_W-1:0] < ID_W'(mfau_pkg::NUM_AUX_OFFSETS)) begin
        dec_o.offset = cfg_i.offset_aux[aux_off[0]];
      end
    end
  end

endmodule

FILE: sv/motor_feedback_angle_unwrap_top.sv
// ----------------------------------------------------------------------------
// motor_feedback_angle_unwrap_top
// Multi-turn angle unwrap of motor feedback frames with per-motor state RAM.
// ----------------------------------------------------------------------------
// throughput: one frame per cycle while out_stall_i does not hold the results,
//   set by the read-modify-write of the state RAM in stage 1, with a one-entry
//   forward for back-to-back frames of a motor
// reset: configuration returns to its defaults and per-motor valid flags clear
//   at once, so every motor reads as angle zero and turn count zero; no sweep
module motor_feedback_angle_unwrap_top #(
  parameter int NUM_CHASSIS_MOTORS = mfau_pkg::NUM_CHASSIS_DEFAULT,
  parameter int NUM_AUX_MOTORS     = mfau_pkg::NUM_AUX_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mfau_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mfau_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // frame requests
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [mfau_pkg::ID_W-1:0]            frame_id_i,
  input  logic [mfau_pkg::RAW_W-1:0]           angle_word_i,
  input  logic signed [mfau_pkg::WORD_W-1:0]   speed_word_i,
  input  logic signed [mfau_pkg::WORD_W-1:0]   current_word_i,
  input  logic [mfau_pkg::TEMP_W-1:0]          temperature_byte_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 matched_o,
  output logic                                 motor_group_o,
  output logic [mfau_pkg::IDX_W-1:0]           motor_index_o,
  output logic [mfau_pkg::RAW_W-1:0]           raw_angle_o,
  output logic [mfau_pkg::ANG_W-1:0]           angle_deg_q10_o,
  output logic signed [mfau_pkg::TC_W-1:0]     turn_count_o,
  output logic signed [mfau_pkg::TOTAL_W-1:0]  total_angle_deg_q10_o,
  output logic signed [mfau_pkg::WORD_W-1:0]   speed_o,
  output logic signed [mfau_pkg::WORD_W-1:0]   current_o,
  output logic [mfau_pkg::TEMP_W-1:0]          temperature_o
);

  localparam int SLOTS   = NUM_CHASSIS_MOTORS + NUM_AUX_MOTORS;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int RAW_W   = mfau_pkg::RAW_W;
  localparam int TC_W    = mfau_pkg::TC_W;
  localparam int WORD_W  = mfau_pkg::WORD_W;
  localparam int TEMP_W  = mfau_pkg::TEMP_W;
  localparam int DIFF_W  = mfau_pkg::DIFF_W;
  localparam int STATE_W = mfau_pkg::STATE_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  mfau_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q              <= '0;
      cfg_q.chassis_base <= mfau_pkg::CHASSIS_BASE_RESET;
      cfg_q.aux_base     <= mfau_pkg::AUX_BASE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mfau_pkg::CFG_CHASSIS_BASE: cfg_q.chassis_base <= cfg_data_i[mfau_pkg::ID_W-1:0];
        mfau_pkg::CFG_AUX_BASE:     cfg_q.aux_base     <= cfg_data_i[mfau_pkg::ID_W-1:0];
        mfau_pkg::CFG_OFF_CHASSIS0: cfg_q.offset_chassis[0] <= cfg_data_i;
        mfau_pkg::CFG_OFF_CHASSIS1: cfg_q.offset_chassis[1] <= cfg_data_i;
        mfau_pkg::CFG_OFF_CHASSIS2: cfg_q.offset_chassis[2] <= cfg_data_i;
        mfau_pkg::CFG_OFF_CHASSIS3: cfg_q.offset_chassis[3] <= cfg_data_i;
        mfau_pkg::CFG_OFF_AUX0:     cfg_q.offset_aux[0]     <= cfg_data_i;
        mfau_pkg::CFG_OFF_AUX1:     cfg_q.offset_aux[1]     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic in_acc, s1_adv;

  assign rdy_out = !out_v_q || !out_stall_i;
  assign rdy3    = !s3_v_q || rdy_out;
  assign rdy2    = !s2_v_q || rdy3;
  assign rdy1    = !s1_v_q || rdy2;

  assign in_stall_o = !rdy1;
  assign in_acc     = in_valid_i && rdy1;
  assign s1_adv     = s1_v_q && rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1)    s1_v_q  <= in_valid_i;
      if (rdy2)    s2_v_q  <= s1_v_q;
      if (rdy3)    s3_v_q  <= s2_v_q;
      if (rdy_out) out_v_q <= s3_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: decode and state read
  // --------------------------------------------------------------------------
  mfau_pkg::dec_t    dec;
  logic [SLOT_W-1:0] dec_slot;
  logic [SLOT_W-1:0] s1_slot_q;

  mfau_decode #(
    .NUM_CHASSIS_MOTORS (NUM_CHASSIS_MOTORS),
    .NUM_AUX_MOTORS     (NUM_AUX_MOTORS)
  ) u_decode (
    .frame_id_i (frame_id_i),
    .cfg_i      (cfg_q),
    .dec_o      (dec),
    .slot_o     (dec_slot)
  );

  logic               ram_we;
  logic [STATE_W-1:0] ram_wdata;
  logic [STATE_W-1:0] ram_rdata;
  logic [SLOTS-1:0]   slot_written_q;

  mfau_ram #(
    .WIDTH (STATE_W),
    .DEPTH (SLOTS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_slot_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (dec_slot),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1: read-modify-write of the motor state
  // --------------------------------------------------------------------------
  mfau_pkg::dec_t            s1_dec_q;
  logic [RAW_W-1:0]          s1_raw_q;
  logic signed [WORD_W-1:0]  s1_speed_q;
  logic signed [WORD_W-1:0]  s1_current_q;
  logic [TEMP_W-1:0]         s1_temp_q;
  logic                      s1_fwd_q;
  logic                      s1_fresh_q;
  logic [STATE_W-1:0]        s1_fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_dec_q      <= dec;
      s1_slot_q     <= dec_slot;
      s1_raw_q      <= angle_word_i;
      s1_speed_q    <= speed_word_i;
      s1_current_q  <= current_word_i;
      s1_temp_q     <= temperature_byte_i;
      // the RAM returns old data when it is written at the read edge
      s1_fwd_q      <= ram_we && (s1_slot_q == dec_slot);
      s1_fwd_data_q <= ram_wdata;
      s1_fresh_q    <= !slot_written_q[dec_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_written_q <= '0;
    end else if (ram_we) begin
      slot_written_q[s1_slot_q] <= 1'b1;
    end
  end

  logic [STATE_W-1:0]       state_old;
  logic [RAW_W-1:0]         last_raw;
  logic signed [TC_W-1:0]   tc_old;
  logic signed [TC_W-1:0]   tc_new;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] rel;

  always_comb begin
    if (s1_fwd_q) begin
      state_old = s1_fwd_data_q;
    end else if (s1_fresh_q) begin
      state_old = '0;
    end else begin
      state_old = ram_rdata;
    end
  end

  assign last_raw = state_old[STATE_W-1:TC_W];
  assign tc_old   = signed'(state_old[TC_W-1:0]);
  assign diff     = signed'({1'b0, s1_raw_q}) - signed'({1'b0, last_raw});
  assign rel      = signed'({1'b0, s1_raw_q}) - signed'({1'b0, s1_dec_q.offset});

  always_comb begin
    tc_new = tc_old;
    if (diff > DIFF_W'(mfau_pkg::HALF_TURN_COUNTS)) begin
      if (tc_old != mfau_pkg::TC_MIN) tc_new = tc_old - TC_W'(1);
    end else if (diff < -DIFF_W'(mfau_pkg::HALF_TURN_COUNTS)) begin
      if (tc_old != mfau_pkg::TC_MAX) tc_new = tc_old + TC_W'(1);
    end
  end

  assign ram_we    = s1_adv && s1_dec_q.matched;
  assign ram_wdata = {s1_raw_q, tc_new};

  // --------------------------------------------------------------------------
  // stage 2: result fields, zeroed for unmatched frames
  // --------------------------------------------------------------------------
  logic                      s2_matched_q;
  logic                      s2_group_q;
  logic [mfau_pkg::IDX_W-1:0] s2_index_q;
  logic [RAW_W-1:0]          s2_raw_q;
  logic signed [TC_W-1:0]    s2_tc_q;
  logic signed [DIFF_W-1:0]  s2_rel_q;
  logic signed [WORD_W-1:0]  s2_speed_q;
  logic signed [WORD_W-1:0]  s2_current_q;
  logic [TEMP_W-1:0]         s2_temp_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_dec_q.matched) begin
        s2_matched_q <= 1'b1;
        s2_group_q   <= s1_dec_q.group;
        s2_index_q   <= s1_dec_q.motor_index;
        s2_raw_q     <= s1_raw_q;
        s2_tc_q      <= tc_new;
        s2_rel_q     <= rel;
        s2_speed_q   <= s1_speed_q;
        s2_current_q <= s1_current_q;
        s2_temp_q    <= s1_temp_q;
      end else begin
        s2_matched_q <= 1'b0;
        s2_group_q   <= 1'b0;
        s2_index_q   <= '0;
        s2_raw_q     <= '0;
        s2_tc_q      <= '0;
        s2_rel_q     <= '0;
        s2_speed_q   <= '0;
        s2_current_q <= '0;
        s2_temp_q    <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: constant scaling
  // --------------------------------------------------------------------------
  logic                        s3_matched_q;
  logic                        s3_group_q;
  logic [mfau_pkg::IDX_W-1:0]  s3_index_q;
  logic [RAW_W-1:0]            s3_raw_q;
  logic [mfau_pkg::ANG_W-1:0]  s3_ang_q;
  logic signed [TC_W-1:0]      s3_tc_q;
  logic signed [mfau_pkg::TC360_W-1:0] s3_tc360_q;
  logic signed [mfau_pkg::REL45_W-1:0] s3_rel45_q;
  logic signed [WORD_W-1:0]    s3_speed_q;
  logic signed [WORD_W-1:0]    s3_current_q;
  logic [TEMP_W-1:0]           s3_temp_q;

  always_ff @(posedge clk_i) begin
    if (s2_v_q && rdy3) begin
      s3_matched_q <= s2_matched_q;
      s3_group_q   <= s2_group_q;
      s3_index_q   <= s2_index_q;
      s3_raw_q     <= s2_raw_q;
      s3_ang_q     <= mfau_pkg::ANG_W'(s2_raw_q)
                      * mfau_pkg::ANG_W'(mfau_pkg::COUNT_DEG_Q10);
      s3_tc_q      <= s2_tc_q;
      s3_tc360_q   <= mfau_pkg::TC360_W'(s2_tc_q)
                      * mfau_pkg::TC360_W'(signed'(mfau_pkg::TURN_DEG));
      s3_rel45_q   <= mfau_pkg::REL45_W'(s2_rel_q)
                      * mfau_pkg::REL45_W'(signed'(mfau_pkg::COUNT_DEG_Q10));
      s3_speed_q   <= s2_speed_q;
      s3_current_q <= s2_current_q;
      s3_temp_q    <= s2_temp_q;
    end
  end

  // --------------------------------------------------------------------------
  // output register: total angle sum
  // --------------------------------------------------------------------------
  logic signed [mfau_pkg::TOTAL_W-1:0] total;

  assign total = signed'({s3_tc360_q, {mfau_pkg::FRAC_BITS{1'b0}}})
               + mfau_pkg::TOTAL_W'(s3_rel45_q);

  always_ff @(posedge clk_i) begin
    if (s3_v_q && rdy_out) begin
      matched_o             <= s3_matched_q;
      motor_group_o         <= s3_group_q;
      motor_index_o         <= s3_index_q;
      raw_angle_o           <= s3_raw_q;
      angle_deg_q10_o       <= s3_ang_q;
      turn_count_o          <= s3_tc_q;
      total_angle_deg_q10_o <= total;
      speed_o               <= s3_speed_q;
      current_o             <= s3_current_q;
      temperature_o         <= s3_temp_q;
    end
  end

  assign out_valid_o = out_v_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_tc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (tc_new == tc_old) || (tc_new == tc_old + TC_W'(1))
               || (tc_new == tc_old - TC_W'(1)))
    else $error("turn count moved by more than one turn");

  a_written_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> slot_written_q[$past(s1_slot_q)])
    else $error("state write did not mark its slot");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !rdy2) |=> s1_v_q && $stable(s1_raw_q) && !$past(ram_we))
    else $error("stage 1 lost or wrote a stalled frame");

  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !matched_o) |-> (total_angle_deg_q10_o == '0)
                                    && (turn_count_o == '0) && (raw_angle_o == '0))
    else $error("unmatched frame carries nonzero result fields");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor feedback angle unwrap block: frame
// requests go in from a queue under random idling and stalls, and a
// cycle-free predictor of the per-motor turn tracking checks every result
// field. Identifier decoding, offsets and wrap detection are exercised under
// several register settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH          = mfau_pkg::NUM_CHASSIS_DEFAULT;
  localparam int NUM_AUX         = mfau_pkg::NUM_AUX_DEFAULT;
  localparam int NUM_SLOTS       = NUM_CH + NUM_AUX;
  localparam int NUM_OFFSETS     = mfau_pkg::NUM_CHASSIS_OFFSETS + mfau_pkg::NUM_AUX_OFFSETS;
  localparam int COUNTS_PER_TURN = 2 * mfau_pkg::HALF_TURN_COUNTS;
  localparam longint TURN_Q10    = longint'(mfau_pkg::TURN_DEG) << mfau_pkg::FRAC_BITS;

  localparam int ID_W       = mfau_pkg::ID_W;
  localparam int RAW_W      = mfau_pkg::RAW_W;
  localparam int WORD_W     = mfau_pkg::WORD_W;
  localparam int TEMP_W     = mfau_pkg::TEMP_W;
  localparam int IDX_W      = mfau_pkg::IDX_W;
  localparam int ANG_W      = mfau_pkg::ANG_W;
  localparam int TC_W       = mfau_pkg::TC_W;
  localparam int TOTAL_W    = mfau_pkg::TOTAL_W;
  localparam int CFG_IDX_W  = mfau_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = mfau_pkg::CFG_DATA_W;

  typedef struct packed {
    logic [ID_W-1:0]          frame_id;
    logic [RAW_W-1:0]         angle_word;
    logic signed [WORD_W-1:0] speed_word;
    logic signed [WORD_W-1:0] current_word;
    logic [TEMP_W-1:0]        temperature_byte;
  } frame_t;

  typedef struct packed {
    logic                      matched;
    logic                      group;
    logic [IDX_W-1:0]          motor_index;
    logic [RAW_W-1:0]          raw_angle;
    logic [ANG_W-1:0]          angle_deg_q10;
    logic signed [TC_W-1:0]    turn_count;
    logic signed [TOTAL_W-1:0] total_angle;
    logic signed [WORD_W-1:0]  speed;
    logic signed [WORD_W-1:0]  current;
    logic [TEMP_W-1:0]         temperature;
  } feedback_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic                     in_valid_i         = 1'b0;
  logic                     in_stall_o;
  logic [ID_W-1:0]          frame_id_i         = '0;
  logic [RAW_W-1:0]         angle_word_i       = '0;
  logic signed [WORD_W-1:0] speed_word_i       = '0;
  logic signed [WORD_W-1:0] current_word_i     = '0;
  logic [TEMP_W-1:0]        temperature_byte_i = '0;

  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      matched_o;
  logic                      motor_group_o;
  logic [IDX_W-1:0]          motor_index_o;
  logic [RAW_W-1:0]          raw_angle_o;
  logic [ANG_W-1:0]          angle_deg_q10_o;
  logic signed [TC_W-1:0]    turn_count_o;
  logic signed [TOTAL_W-1:0] total_angle_deg_q10_o;
  logic signed [WORD_W-1:0]  speed_o;
  logic signed [WORD_W-1:0]  current_o;
  logic [TEMP_W-1:0]         temperature_o;

  frame_t     frame_q[$];
  reg_write_t reg_write_q[$];
  feedback_t  expected_feedback_q[$];

  // predictor state and register copy
  mfau_pkg::cfg_t unwrap_cfg;
  int   motor_last_angle [NUM_SLOTS];
  int   motor_turns [NUM_SLOTS];

  // stimulus side: where each motor's simulated rotor sits
  int sweep_pos [NUM_SLOTS];
  int idle_pct;
  int mismatch_count;

  motor_feedback_angle_unwrap_top u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .frame_id_i            (frame_id_i),
    .angle_word_i          (angle_word_i),
    .speed_word_i          (speed_word_i),
    .current_word_i        (current_word_i),
    .temperature_byte_i    (temperature_byte_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .matched_o             (matched_o),
    .motor_group_o         (motor_group_o),
    .motor_index_o         (motor_index_o),
    .raw_angle_o           (raw_angle_o),
    .angle_deg_q10_o       (angle_deg_q10_o),
    .turn_count_o          (turn_count_o),
    .total_angle_deg_q10_o (total_angle_deg_q10_o),
    .speed_o               (speed_o),
    .current_o             (current_o),
    .temperature_o         (temperature_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decode the identifier, unwrap the angle and update that motor's state
  function automatic feedback_t unwrap_frame(frame_t f);
    feedback_t fb;
    int id_v, raw_v, chassis_v, aux_v, slot, idx, tc;
    longint off_v, total_v;
    fb = '0;
    id_v = f.frame_id;
    raw_v = f.angle_word;
    chassis_v = unwrap_cfg.chassis_base;
    aux_v = unwrap_cfg.aux_base;
    slot = -1;
    idx = 0;
    off_v = 0;
    // chassis group wins when both ranges hold the identifier
    if (id_v >= chassis_v && id_v - chassis_v < NUM_CH) begin
      idx = id_v - chassis_v;
      slot = idx;
      fb.group = 1'b0;
      if (idx < mfau_pkg::NUM_CHASSIS_OFFSETS) off_v = unwrap_cfg.offset_chassis[idx];
    end else if (id_v >= aux_v && id_v - aux_v < NUM_AUX) begin
      idx = id_v - aux_v;
      slot = NUM_CH + idx;
      fb.group = 1'b1;
      if (idx < mfau_pkg::NUM_AUX_OFFSETS) off_v = unwrap_cfg.offset_aux[idx];
    end
    if (slot < 0) return fb;

    tc = motor_turns[slot];
    if (raw_v - motor_last_angle[slot] > mfau_pkg::HALF_TURN_COUNTS) begin
      if (tc > mfau_pkg::TC_MIN) tc--;
    end else if (raw_v - motor_last_angle[slot] < -mfau_pkg::HALF_TURN_COUNTS) begin
      if (tc < mfau_pkg::TC_MAX) tc++;
    end
    motor_turns[slot] = tc;
    motor_last_angle[slot] = raw_v;

    total_v = longint'(tc) * TURN_Q10
            + (longint'(raw_v) - off_v) * mfau_pkg::COUNT_DEG_Q10;
    fb.matched       = 1'b1;
    fb.motor_index   = IDX_W'(idx);
    fb.raw_angle     = f.angle_word;
    fb.angle_deg_q10 = ANG_W'(raw_v * mfau_pkg::COUNT_DEG_Q10);
    fb.turn_count    = TC_W'(tc);
    fb.total_angle   = TOTAL_W'(total_v);
    fb.speed         = f.speed_word;
    fb.current       = f.current_word;
    fb.temperature   = f.temperature_byte;
    return fb;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic queue_frame(input int id, input int angle, input int speed,
                             input int current, input int temp);
    frame_t f;
    f.frame_id         = ID_W'(id);
    f.angle_word       = RAW_W'(angle);
    f.speed_word       = WORD_W'(speed);
    f.current_word     = WORD_W'(current);
    f.temperature_byte = TEMP_W'(temp);
    frame_q.push_back(f);
  endtask

  // mostly frames of a known motor turning steadily, some stray identifiers
  task automatic queue_random_frames(input int count);
    int s, step, id;
    for (int n = 0; n < count; n++) begin
      s = $urandom_range(NUM_SLOTS - 1);
      id = (s < NUM_CH) ? int'(unwrap_cfg.chassis_base) + s
                        : int'(unwrap_cfg.aux_base) + s - NUM_CH;
      case ($urandom_range(9))
        0: queue_frame($urandom, $urandom, $urandom, $urandom, $urandom);
        1: begin
          sweep_pos[s] = $urandom_range(16'hffff);
          queue_frame(id, sweep_pos[s], $urandom, $urandom, $urandom);
        end
        2: begin
          // jumps of up to a full turn either way
          sweep_pos[s] += $urandom_range(2 * COUNTS_PER_TURN) - COUNTS_PER_TURN;
          queue_frame(id, sweep_pos[s] & (COUNTS_PER_TURN - 1), $urandom, $urandom,
                      $urandom);
        end
        default: begin
          step = $urandom_range(2000) - 500;
          sweep_pos[s] += (s % 2 == 1) ? -step : step;
          queue_frame(id, sweep_pos[s] & (COUNTS_PER_TURN - 1), $urandom, $urandom,
                      $urandom);
        end
      endcase
    end
  endtask

  task automatic drain();
    while (frame_q.size() != 0 || in_valid_i || expected_feedback_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] chassis_word,
                              input logic [CFG_DATA_W-1:0] aux_word,
                              input logic [CFG_DATA_W-1:0] offsets [NUM_OFFSETS]);
    reg_write_t w;
    drain();
    w.index = mfau_pkg::CFG_CHASSIS_BASE;
    w.data  = chassis_word;
    reg_write_q.push_back(w);
    w.index = mfau_pkg::CFG_AUX_BASE;
    w.data  = aux_word;
    reg_write_q.push_back(w);
    for (int i = 0; i < NUM_OFFSETS; i++) begin
      w.index = CFG_IDX_W'(mfau_pkg::CFG_OFF_CHASSIS0 + i);
      w.data  = offsets[i];
      reg_write_q.push_back(w);
    end
    while (reg_write_q.size() != 0 || cfg_valid_i) @(negedge clk_i);
  endtask

  // drives requests, register writes and the result stall
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    frame_t next_frame;
    reg_write_t next_write;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
      if (!in_valid_i || !in_stall_o) begin
        if (frame_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_frame = frame_q.pop_front();
          in_valid_i         <= 1'b1;
          frame_id_i         <= next_frame.frame_id;
          angle_word_i       <= next_frame.angle_word;
          speed_word_i       <= next_frame.speed_word;
          current_word_i     <= next_frame.current_word;
          temperature_byte_i <= next_frame.temperature_byte;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_write_q.size() != 0) begin
          next_write = reg_write_q.pop_front();
          cfg_valid_i <= 1'b1;
          cfg_index_i <= next_write.index;
          cfg_data_i  <= next_write.data;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // mirrors register writes, predicts on accepted requests, then checks accepted results
  always @(posedge clk_i) begin : check_results
    feedback_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          mfau_pkg::CFG_CHASSIS_BASE: unwrap_cfg.chassis_base = cfg_data_i[ID_W-1:0];
          mfau_pkg::CFG_AUX_BASE:     unwrap_cfg.aux_base = cfg_data_i[ID_W-1:0];
          mfau_pkg::CFG_OFF_CHASSIS0, mfau_pkg::CFG_OFF_CHASSIS1,
          mfau_pkg::CFG_OFF_CHASSIS2, mfau_pkg::CFG_OFF_CHASSIS3:
            unwrap_cfg.offset_chassis[cfg_index_i - mfau_pkg::CFG_OFF_CHASSIS0] = cfg_data_i;
          mfau_pkg::CFG_OFF_AUX0, mfau_pkg::CFG_OFF_AUX1:
            unwrap_cfg.offset_aux[cfg_index_i - mfau_pkg::CFG_OFF_AUX0] = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        expected_feedback_q.push_back(unwrap_frame({frame_id_i, angle_word_i, speed_word_i,
                                                    current_word_i, temperature_byte_i}));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_feedback_q.size() == 0) begin
          $display("%0t: result with no request waiting", $time);
          mismatch_count++;
        end else begin
          want = expected_feedback_q.pop_front();
          check_field("matched", want.matched, matched_o);
          check_field("motor_group", want.group, motor_group_o);
          check_field("motor_index", want.motor_index, motor_index_o);
          check_field("raw_angle", want.raw_angle, raw_angle_o);
          check_field("angle_deg_q10", want.angle_deg_q10, angle_deg_q10_o);
          check_field("turn_count", want.turn_count, turn_count_o);
          check_field("total_angle_deg_q10", want.total_angle, total_angle_deg_q10_o);
          check_field("speed", want.speed, speed_o);
          check_field("current", want.current, current_o);
          check_field("temperature", want.temperature, temperature_o);
        end
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] offsets [NUM_OFFSETS];
    mismatch_count = 0;
    idle_pct = 30;
    unwrap_cfg.chassis_base = mfau_pkg::CHASSIS_BASE_RESET;
    unwrap_cfg.aux_base = mfau_pkg::AUX_BASE_RESET;
    unwrap_cfg.offset_chassis = '0;
    unwrap_cfg.offset_aux = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      motor_last_angle[i] = 0;
      motor_turns[i] = 0;
      sweep_pos[i] = 0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset identifiers: chassis 513..516, auxiliary 517..518
    queue_frame(0, 0, 32767, -32768, 255);
    queue_frame(2047, 65535, -32768, 32767, 0);
    queue_frame(512, $urandom, $urandom, $urandom, $urandom);
    queue_frame(519, $urandom, $urandom, $urandom, $urandom);
    // first frame after reset above half a turn counts down
    queue_frame(513, 5000, $urandom, $urandom, $urandom);
    // jumps of exactly half a turn keep the count, one more moves it
    queue_frame(513, 904, $urandom, $urandom, $urandom);
    queue_frame(513, 5000, $urandom, $urandom, $urandom);
    queue_frame(513, 903, $urandom, $urandom, $urandom);
    queue_frame(513, 5000, $urandom, $urandom, $urandom);
    // raw angle beyond one turn is taken as is
    queue_frame(514, 65535, $urandom, $urandom, $urandom);
    queue_frame(514, 0, $urandom, $urandom, $urandom);
    queue_frame(515, 4096, $urandom, $urandom, $urandom);
    queue_frame(516, 8191, $urandom, $urandom, $urandom);
    queue_frame(517, 4097, -32768, 32767, $urandom);
    queue_frame(518, 100, 32767, -32768, 255);
    queue_frame(518, 8000, $urandom, $urandom, 0);
    queue_frame(518, 100, $urandom, $urandom, $urandom);
    queue_random_frames(150);

    // overlapping ranges with stray upper data bits, largest offsets
    foreach (offsets[i]) offsets[i] = '1;
    program_regs(16'hf800, 16'hf802, offsets);
    queue_random_frames(160);

    // top of the identifier space, no wrap past it
    foreach (offsets[i]) offsets[i] = '0;
    program_regs(16'd2047, 16'd2044, offsets);
    queue_random_frames(160);

    // random setting, back-to-back traffic
    foreach (offsets[i]) offsets[i] = $urandom;
    program_regs($urandom, $urandom, offsets);
    idle_pct = 0;
    queue_random_frames(160);

    foreach (offsets[i]) offsets[i] = $urandom;
    program_regs({5'($urandom), mfau_pkg::CHASSIS_BASE_RESET},
                 {5'($urandom), mfau_pkg::AUX_BASE_RESET}, offsets);
    idle_pct = 30;
    queue_random_frames(160);

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("motor_feedback_angle_unwrap_top verification clean");
    end else begin
      $display("motor_feedback_angle_unwrap_top verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("motor_feedback_angle_unwrap_top verification failed");
    $finish;
  end

endmodule
